### design/bfd_pkg.sv
package bfd_pkg;

	// Field type codes carried on req_type.
	localparam logic [3:0] FT_BOOL    = 4'd0;
	localparam logic [3:0] FT_U8      = 4'd1;
	localparam logic [3:0] FT_U64     = 4'd4;
	localparam logic [3:0] FT_I8      = 4'd5;
	localparam logic [3:0] FT_I64     = 4'd8;
	localparam logic [3:0] FT_VARUINT = 4'd9;
	localparam logic [3:0] FT_VARINT  = 4'd10;
	localparam logic [3:0] FT_LENPFX  = 4'd11;
	localparam logic [3:0] FT_RAW     = 4'd12;

	// Result kind codes.
	localparam logic [2:0] KIND_SCALAR   = 3'd0;
	localparam logic [2:0] KIND_LENGTH   = 3'd1;
	localparam logic [2:0] KIND_PAYLOAD  = 3'd2;
	localparam logic [2:0] KIND_TOO_BIG  = 3'd3;
	localparam logic [2:0] KIND_TOO_LONG = 3'd4;

	// Depth of the queues between front, back and the result port.
	localparam int QUEUE_DEPTH = 2;

	// One byte of the serialized stream as it arrives.
	typedef struct packed {
		logic [3:0]  req_type;
		logic [7:0]  data_byte;
		logic        field_start;
		logic [15:0] bytes_remaining;
		logic [7:0]  raw_length;
	} in_item_t;

	// One decoded result.
	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] value;
		logic [4:0]  bytes_used;
		logic        last;
	} out_item_t;

	// A byte after classification by the front part.
	typedef struct packed {
		logic [3:0]  req_type;
		logic [7:0]  data_byte;
		logic        field_start;
		logic [15:0] bytes_remaining;
		logic [7:0]  raw_length;
		logic        type_bad;
		logic        raw_start;
		logic        raw_too_big;
		logic        raw_zero;
		logic [7:0]  raw_left;
	} cls_item_t;

	// Byte size of a fixed-size field type.
	function automatic logic [3:0] fixed_size(input logic [3:0] ft);
		logic [3:0] n;
		case (ft)
			4'd2, 4'd6: n = 4'd2;
			4'd3, 4'd7: n = 4'd4;
			4'd4, 4'd8: n = 4'd8;
			default:    n = 4'd1;
		endcase
		return n;
	endfunction

endpackage

### design/bfd_fifo.sv
module bfd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             full,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (PW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign head    = slots_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Entry storage; written only on a transfer in.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

### design/bfd_front.sv
module bfd_front (
	input  bfd_pkg::in_item_t  item,
	output bfd_pkg::cls_item_t cls
);
	import bfd_pkg::*;

	logic [16:0] rem_plus_one;

	assign rem_plus_one = {1'b0, item.bytes_remaining} + 17'd1;

	// Classify a byte: everything that depends only on the byte itself,
	// including the checks on a raw field's start, is settled here.
	always_comb begin
		cls.req_type        = item.req_type;
		cls.data_byte       = item.data_byte;
		cls.field_start     = item.field_start;
		cls.bytes_remaining = item.bytes_remaining;
		cls.raw_length      = item.raw_length;
		cls.type_bad        = item.req_type > FT_RAW;
		cls.raw_start       = item.req_type == FT_RAW;
		cls.raw_too_big     = {9'd0, item.raw_length} > rem_plus_one;
		cls.raw_zero        = item.raw_length == 8'd0;
		cls.raw_left        = item.raw_length - 8'd1;
	end
endmodule

### design/bfd_back.sv
module bfd_back #(
	parameter int LENGTH_BITS      = 16,
	parameter int MAX_VARINT_BYTES = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bfd_pkg::cls_item_t  cls,
	input  logic                item_valid,
	output logic                item_pop,
	input  logic                res_full,
	output logic                res_push,
	output bfd_pkg::out_item_t  res
);
	import bfd_pkg::*;

	// Field state.
	logic [3:0]  ft_q;
	logic [63:0] acc_q;
	logic [3:0]  bc_q;
	logic [6:0]  sh_q;
	logic [15:0] pl_q;
	logic        inp_q;

	logic [3:0]  nxt_ft;
	logic [63:0] nxt_acc;
	logic [3:0]  nxt_bc;
	logic [6:0]  nxt_sh;
	logic [15:0] nxt_pl;
	logic        nxt_inp;

	// Scalar state as seen by this byte (cleared on a field start).
	logic [3:0]  eff_ft;
	logic [63:0] eff_acc;
	logic [3:0]  eff_bc;
	logic [6:0]  eff_sh;

	logic        do_scalar;
	logic        rv;
	logic [3:0]  bc_inc;
	logic [63:0] var_acc;
	logic [6:0]  sh_next_group;
	logic [63:0] var_val;
	logic        len_too_big;
	logic [3:0]  fix_n;
	logic [63:0] fix_acc;
	logic [63:0] fix_val;
	logic [15:0] pl_dec;
	logic        is_varint;

	assign item_pop = item_valid && !res_full;
	assign res_push = item_pop && rv;

	// Datapath for one byte of a scalar or length prefix.
	always_comb begin
		bc_inc        = eff_bc + 4'd1;
		is_varint     = (eff_ft >= FT_VARUINT) && (eff_ft <= FT_LENPFX);
		// Varint: or seven payload bits in at the current bit position.
		var_acc       = eff_acc;
		if (!eff_sh[6]) begin
			var_acc = eff_acc | ({57'd0, cls.data_byte[6:0]} << eff_sh[5:0]);
		end
		sh_next_group = eff_sh + 7'd7;
		var_val       = var_acc;
		if (eff_ft == FT_VARINT && cls.data_byte[6] && !sh_next_group[6]) begin
			var_val = var_acc | ({64{1'b1}} << sh_next_group[5:0]);
		end
		len_too_big   = ((var_acc >> LENGTH_BITS) != 64'd0)
			|| (var_acc > {48'd0, cls.bytes_remaining});
		// Fixed-size little-endian: one byte lane per byte count.
		fix_n         = fixed_size(eff_ft);
		fix_acc       = eff_acc | ({56'd0, cls.data_byte} << {eff_bc[2:0], 3'b000});
		fix_val       = fix_acc;
		if (eff_ft == FT_BOOL) begin
			fix_val = {63'd0, fix_acc != 64'd0};
		end else if (eff_ft >= FT_I8) begin
			case (fix_n)
				4'd1: if (fix_acc[7])  fix_val = fix_acc | ({64{1'b1}} << 8);
				4'd2: if (fix_acc[15]) fix_val = fix_acc | ({64{1'b1}} << 16);
				4'd4: if (fix_acc[31]) fix_val = fix_acc | ({64{1'b1}} << 32);
				default: fix_val = fix_acc;
			endcase
		end
		pl_dec = (pl_q != 16'd0) ? pl_q - 16'd1 : pl_q;
	end

	// Field sequencing: start, payload pass-through, scalar and prefix bytes.
	always_comb begin
		nxt_ft    = ft_q;
		nxt_acc   = acc_q;
		nxt_bc    = bc_q;
		nxt_sh    = sh_q;
		nxt_pl    = pl_q;
		nxt_inp   = inp_q;
		eff_ft    = ft_q;
		eff_acc   = acc_q;
		eff_bc    = bc_q;
		eff_sh    = sh_q;
		do_scalar = 1'b0;
		rv        = 1'b0;
		res       = '{kind: KIND_SCALAR, value: 64'd0, bytes_used: 5'd0, last: 1'b0};

		if (cls.field_start) begin
			eff_ft  = cls.req_type;
			eff_acc = 64'd0;
			eff_bc  = 4'd0;
			eff_sh  = 7'd0;
			nxt_ft  = cls.req_type;
			nxt_acc = 64'd0;
			nxt_bc  = 4'd0;
			nxt_sh  = 7'd0;
			nxt_pl  = 16'd0;
			nxt_inp = 1'b0;
			if (cls.type_bad) begin
				rv = 1'b0;
			end else if (cls.raw_start) begin
				rv = 1'b1;
				if (cls.raw_too_big) begin
					res.kind  = KIND_TOO_BIG;
					res.value = {56'd0, cls.raw_length};
					res.last  = 1'b1;
				end else if (cls.raw_zero) begin
					res.kind  = KIND_LENGTH;
					res.last  = 1'b1;
				end else begin
					nxt_pl    = {8'd0, cls.raw_left};
					nxt_inp   = cls.raw_left != 8'd0;
					res.kind  = KIND_PAYLOAD;
					res.value = {56'd0, cls.data_byte};
					res.last  = cls.raw_left == 8'd0;
				end
			end else begin
				do_scalar = 1'b1;
			end
		end else if (inp_q) begin
			nxt_pl    = pl_dec;
			nxt_inp   = pl_dec != 16'd0;
			rv        = 1'b1;
			res.kind  = KIND_PAYLOAD;
			res.value = {56'd0, cls.data_byte};
			res.last  = pl_dec == 16'd0;
		end else if (bc_q != 4'd0) begin
			do_scalar = 1'b1;
		end

		if (do_scalar) begin
			if (is_varint) begin
				if (cls.data_byte[7]) begin
					if (bc_inc >= 4'(MAX_VARINT_BYTES)) begin
						nxt_acc        = 64'd0;
						nxt_bc         = 4'd0;
						nxt_sh         = 7'd0;
						rv             = 1'b1;
						res.kind       = KIND_TOO_LONG;
						res.bytes_used = {1'b0, bc_inc};
						res.last       = 1'b1;
					end else begin
						nxt_acc = var_acc;
						nxt_bc  = bc_inc;
						nxt_sh  = sh_next_group;
					end
				end else begin
					nxt_acc        = 64'd0;
					nxt_bc         = 4'd0;
					nxt_sh         = 7'd0;
					rv             = 1'b1;
					res.bytes_used = {1'b0, bc_inc};
					res.last       = 1'b1;
					if (eff_ft == FT_LENPFX) begin
						res.value = var_acc;
						if (len_too_big) begin
							res.kind = KIND_TOO_BIG;
						end else begin
							res.kind = KIND_LENGTH;
							if (var_acc != 64'd0) begin
								nxt_inp  = 1'b1;
								nxt_pl   = var_acc[15:0];
								res.last = 1'b0;
							end
						end
					end else begin
						res.kind  = KIND_SCALAR;
						res.value = var_val;
					end
				end
			end else if (eff_ft <= FT_I64) begin
				if (bc_inc < fix_n) begin
					nxt_acc = fix_acc;
					nxt_bc  = bc_inc;
				end else begin
					nxt_acc        = 64'd0;
					nxt_bc         = 4'd0;
					nxt_sh         = 7'd0;
					rv             = 1'b1;
					res.kind       = KIND_SCALAR;
					res.value      = fix_val;
					res.bytes_used = {1'b0, fix_n};
					res.last       = 1'b1;
				end
			end else begin
				nxt_acc = 64'd0;
				nxt_bc  = 4'd0;
				nxt_sh  = 7'd0;
			end
		end
	end

	// State update on each transfer out of the item queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ft_q  <= 4'd0;
			acc_q <= 64'd0;
			bc_q  <= 4'd0;
			sh_q  <= 7'd0;
			pl_q  <= 16'd0;
			inp_q <= 1'b0;
		end else if (item_pop) begin
			ft_q  <= nxt_ft;
			acc_q <= nxt_acc;
			bc_q  <= nxt_bc;
			sh_q  <= nxt_sh;
			pl_q  <= nxt_pl;
			inp_q <= nxt_inp;
		end
	end
endmodule

### design/binary_field_deserializer_top.sv
// Each byte is registered in the item queue and its result in the result queue; a full
// result queue holds the byte back.
// Throughput: one byte per cycle while the result queue is not full;
// a byte yields at most one result.
// Reset: arst_n clears all field state and empties both internal queues.
module binary_field_deserializer_top #(
	parameter int LENGTH_BITS      = 16,
	parameter int MAX_VARINT_BYTES = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  bfd_pkg::in_item_t   item,
	output logic                empty,
	input  logic                pop,
	output bfd_pkg::out_item_t  result
);
	import bfd_pkg::*;

	cls_item_t cls_in;
	cls_item_t cls_head;
	logic      item_empty;
	logic      item_pop;
	logic      res_full;
	logic      res_push;
	out_item_t res_data;

	// Front: classify each byte.
	bfd_front u_front (
		.item (item),
		.cls  (cls_in)
	);

	// Queue between front and back.
	bfd_fifo #(
		.WIDTH ($bits(cls_item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls_in),
		.pop    (item_pop),
		.head   (cls_head),
		.full   (full),
		.empty  (item_empty)
	);

	// Back: field state and decode.
	bfd_back #(
		.LENGTH_BITS      (LENGTH_BITS),
		.MAX_VARINT_BYTES (MAX_VARINT_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cls        (cls_head),
		.item_valid (!item_empty),
		.item_pop   (item_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res_data)
	);

	// Result queue toward the consumer.
	bfd_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_data),
		.pop    (pop),
		.head   (result),
		.full   (res_full),
		.empty  (empty)
	);
endmodule

### tb/binary_field_deserializer_top_tb.sv
module binary_field_deserializer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bfd_pkg::*;

	localparam int LEN_BITS   = 16;
	localparam int MAX_VARINT = 10;

	// Field types that the package does not name.
	localparam logic [3:0] FT_U16    = 4'd2;
	localparam logic [3:0] FT_U32    = 4'd3;
	localparam logic [3:0] FT_I16    = 4'd6;
	localparam logic [3:0] FT_I32    = 4'd7;
	localparam logic [3:0] FT_BAD_LO = 4'd13;
	localparam logic [3:0] FT_BAD_HI = 4'd15;

	typedef logic [7:0] byte_q_t[$];

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      empty;
	logic      pop;
	out_item_t result;

	bit tx_idle;
	bit rx_idle;
	int pop_hold;
	int fail_count;
	int items_sent;

	// Decoder state as the testbench tracks it.
	logic [3:0]  cur_type;
	logic [63:0] acc;
	logic [3:0]  taken;
	logic [6:0]  vshift;
	logic [15:0] pay_left;
	logic        in_pay;

	// Decoded results still owed by the block, oldest first.
	out_item_t pending_results[$];

	binary_field_deserializer_top #(
		.LENGTH_BITS      (LEN_BITS),
		.MAX_VARINT_BYTES (MAX_VARINT)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#1_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic int field_bytes(input logic [3:0] ft);
		case (ft)
			FT_U16, FT_I16: return 2;
			FT_U32, FT_I32: return 4;
			FT_U64, FT_I64: return 8;
			default:        return 1;
		endcase
	endfunction

	function automatic out_item_t pack_result(input logic [2:0] k, input logic [63:0] v,
			input logic [4:0] u, input logic l);
		out_item_t r;
		r.kind       = k;
		r.value      = v;
		r.bytes_used = u;
		r.last       = l;
		return r;
	endfunction

	function void clear_scalar();
		acc    = '0;
		taken  = '0;
		vshift = '0;
	endfunction

	// Advances the tracked decoder by one byte; returns 1 when the byte yields a result.
	function automatic bit decode_byte(input in_item_t b, output out_item_t r);
		logic [63:0] v;
		logic [4:0]  used;
		int          n;
		int          bits;
		r = '0;
		if (b.field_start) begin
			cur_type = b.req_type;
			clear_scalar();
			pay_left = '0;
			in_pay   = 1'b0;
			if (b.req_type > FT_RAW)
				return 1'b0;
			if (b.req_type == FT_RAW) begin
				if (int'(b.raw_length) > int'(b.bytes_remaining) + 1) begin
					r = pack_result(KIND_TOO_BIG, 64'(b.raw_length), 5'd0, 1'b1);
					return 1'b1;
				end
				if (b.raw_length == 8'd0) begin
					r = pack_result(KIND_LENGTH, 64'd0, 5'd0, 1'b1);
					return 1'b1;
				end
				pay_left = 16'(b.raw_length) - 16'd1;
				in_pay   = (pay_left != 16'd0);
				r = pack_result(KIND_PAYLOAD, 64'(b.data_byte), 5'd0, pay_left == 16'd0);
				return 1'b1;
			end
		end else if (in_pay) begin
			if (pay_left != 16'd0)
				pay_left = pay_left - 16'd1;
			if (pay_left == 16'd0)
				in_pay = 1'b0;
			r = pack_result(KIND_PAYLOAD, 64'(b.data_byte), 5'd0, pay_left == 16'd0);
			return 1'b1;
		end else if (taken == 4'd0) begin
			return 1'b0;
		end

		// Varints and length prefixes: seven bits per byte, low group first.
		if (cur_type >= FT_VARUINT && cur_type <= FT_LENPFX) begin
			if (vshift < 7'd64)
				acc |= 64'(b.data_byte[6:0]) << vshift;
			taken = taken + 4'd1;
			used  = 5'(taken);
			if (b.data_byte[7]) begin
				if (int'(taken) >= MAX_VARINT) begin
					clear_scalar();
					r = pack_result(KIND_TOO_LONG, 64'd0, used, 1'b1);
					return 1'b1;
				end
				vshift = vshift + 7'd7;
				return 1'b0;
			end
			v = acc;
			if (cur_type == FT_VARINT && b.data_byte[6] && int'(vshift) + 7 < 64)
				v |= ~64'd0 << (int'(vshift) + 7);
			clear_scalar();
			if (cur_type != FT_LENPFX) begin
				r = pack_result(KIND_SCALAR, v, used, 1'b1);
				return 1'b1;
			end
			if ((v >> LEN_BITS) != 64'd0 || v > 64'(b.bytes_remaining)) begin
				r = pack_result(KIND_TOO_BIG, v, used, 1'b1);
				return 1'b1;
			end
			if (v != 64'd0) begin
				in_pay   = 1'b1;
				pay_left = v[15:0];
			end
			r = pack_result(KIND_LENGTH, v, used, v == 64'd0);
			return 1'b1;
		end

		// Fixed-size little-endian fields.
		if (cur_type <= FT_I64) begin
			acc |= 64'(b.data_byte) << (8 * int'(taken[2:0]));
			taken = taken + 4'd1;
			n = field_bytes(cur_type);
			if (int'(taken) < n)
				return 1'b0;
			v    = acc;
			bits = 8 * n;
			if (cur_type == FT_BOOL)
				v = 64'(v != 64'd0);
			else if (cur_type >= FT_I8 && bits < 64 && v[bits-1])
				v |= ~64'd0 << bits;
			clear_scalar();
			r = pack_result(KIND_SCALAR, v, 5'(n), 1'b1);
			return 1'b1;
		end
		clear_scalar();
		return 1'b0;
	endfunction

	// Predict the results of every input transfer.
	always @(posedge clk) begin : predict_inputs
		out_item_t r;
		if (arst_n && push && !full) begin
			if (decode_byte(item, r))
				pending_results.push_back(r);
		end
	end

	// The receiver stalls in random bursts while rx_idle is set.
	always @(posedge clk) begin
		if (pop_hold > 0) begin
			pop_hold = pop_hold - 1;
			pop <= 1'b0;
		end else if (rx_idle && $urandom_range(0, 7) == 0) begin
			pop_hold = $urandom_range(0, 9);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// Compare each result transfer with the oldest prediction.
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				$error("result with no expectation: kind %0d, value %h", result.kind,
					result.value);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.kind !== want.kind) begin
					$error("kind: expected %0d, actual %0d", want.kind, result.kind);
					fail_count++;
				end
				if (result.value !== want.value) begin
					$error("value: expected %h, actual %h", want.value, result.value);
					fail_count++;
				end
				if (result.bytes_used !== want.bytes_used) begin
					$error("bytes_used: expected %0d, actual %0d", want.bytes_used,
						result.bytes_used);
					fail_count++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, result.last);
					fail_count++;
				end
			end
		end
	end

	function automatic logic [7:0] rand_data();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Sends one byte, with a random gap before it while tx_idle is set.
	task automatic send_byte(input in_item_t it);
		if (tx_idle && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// Sends the bytes of one field; the first one opens the field.
	task automatic send_field(input logic [3:0] ft, input byte_q_t seq, input logic [15:0] rem,
			input logic [7:0] rlen);
		in_item_t it;
		int       i;
		for (i = 0; i < seq.size(); i++) begin
			it.field_start     = (i == 0);
			it.req_type        = (i == 0) ? ft : 4'($urandom);
			it.data_byte       = seq[i];
			it.bytes_remaining = rem;
			it.raw_length      = (i == 0) ? rlen : 8'($urandom);
			send_byte(it);
			items_sent++;
		end
	endtask

	task automatic build_varint(ref byte_q_t seq, input int n, input bit saturate);
		logic [6:0] g;
		int         i;
		for (i = 0; i < n; i++) begin
			g = 7'($urandom);
			if (saturate)
				g = 7'h7F;
			else if ($urandom_range(0, 3) == 0)
				g = {7{g[0]}};
			seq.push_back({i != n - 1, g});
		end
	endtask

	// Length prefix, padded with zero groups when pad is set, then the payload it announces if it fits.
	task automatic build_prefixed(ref byte_q_t seq, input logic [63:0] len,
			input logic [15:0] rem, input int pad);
		logic [63:0] v;
		logic [6:0]  g;
		int          i;
		v = len;
		do begin
			g = v[6:0];
			v = v >> 7;
			seq.push_back({v != 64'd0 || pad > 0, g});
		end while (v != 64'd0);
		for (i = 0; i < pad; i++)
			seq.push_back({i != pad - 1, 7'd0});
		if (seq.size() <= MAX_VARINT && len <= 64'(rem) && len < 64'd65536)
			repeat (int'(len)) seq.push_back(rand_data());
	endtask

	function automatic int pick_varint_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return $urandom_range(1, 2);
		if (r < 8)
			return $urandom_range(3, 9);
		if (r == 8)
			return 10;
		return $urandom_range(11, 12);
	endfunction

	// One field of random type and content; broken_pct sets how often it is cut short or
	// followed by a stray byte.
	task automatic send_random_field(input int broken_pct);
		byte_q_t     seq;
		logic [3:0]  ft;
		logic [15:0] rem;
		logic [7:0]  rlen;
		logic [63:0] len;
		int          pick;
		int          n;
		rem  = 16'($urandom);
		rlen = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			ft = 4'($urandom_range(0, 8));
			repeat (field_bytes(ft)) seq.push_back(rand_data());
		end else if (pick < 55) begin
			ft = $urandom_range(0, 1) ? FT_VARINT : FT_VARUINT;
			build_varint(seq, pick_varint_len(), 1'b0);
		end else if (pick < 75) begin
			ft   = FT_LENPFX;
			pick = $urandom_range(0, 19);
			if (pick == 0)
				len = 64'd0;
			else if (pick < 16)
				len = $urandom_range(1, 12);
			else if (pick < 18)
				len = $urandom_range(13, 200);
			else
				len = $urandom_range(65536, 2 ** 21);
			if (len > 64'd65535)
				rem = 16'hFFFF;
			else if (len != 64'd0 && $urandom_range(0, 5) == 0)
				rem = 16'(len - 64'd1);
			else
				rem = 16'(len + 64'($urandom_range(0, 3)));
			build_prefixed(seq, len, rem,
				($urandom_range(0, 15) == 0) ? $urandom_range(1, 9) : 0);
		end else if (pick < 93) begin
			ft   = FT_RAW;
			pick = $urandom_range(0, 19);
			if (pick == 0)
				rlen = 8'd0;
			else if (pick < 14)
				rlen = 8'($urandom_range(1, 8));
			else if (pick < 16)
				rlen = 8'($urandom_range(9, 255));
			if (pick > 0 && pick < 16) begin
				rem = 16'(int'(rlen) - 1 + $urandom_range(0, 65280));
				n   = rlen;
			end else begin
				if (pick >= 16) begin
					rlen = 8'($urandom_range(2, 255));
					rem  = 16'($urandom_range(0, int'(rlen) - 2));
				end
				n = 1;
			end
			repeat (n) seq.push_back(rand_data());
		end else begin
			ft = 4'($urandom_range(FT_BAD_LO, FT_BAD_HI));
			seq.push_back(rand_data());
		end
		if (seq.size() > 1 && $urandom_range(0, 99) < broken_pct) begin
			n = $urandom_range(1, seq.size() - 1);
			while (seq.size() > n) void'(seq.pop_back());
		end
		if ($urandom_range(0, 99) < broken_pct / 2)
			seq.push_back(rand_data());
		send_field(ft, seq, rem, rlen);
	endtask

	// Field extremes, a selection of types and the corner cases of the decoder.
	task automatic test_directed();
		in_item_t stray;
		stray                 = in_item_t'($urandom);
		stray.field_start     = 1'b0;
		send_byte(stray);
		send_field(FT_BAD_LO, '{8'hFF}, 16'hFFFF, 8'hFF);
		send_field(FT_BAD_HI, '{8'h00}, 16'h0000, 8'h00);
		send_field(FT_BOOL, '{8'h00}, 16'h0000, 8'h00);
		send_field(FT_BOOL, '{8'h80}, 16'hFFFF, 8'hFF);
		send_field(FT_U8, '{8'hFF}, 16'h1234, 8'h00);
		send_field(FT_I8, '{8'h80}, 16'h0001, 8'h00);
		// A u64 cut short by the next field start.
		send_field(FT_U64, '{8'h11, 8'h22}, 16'h0010, 8'h00);
		send_field(FT_I16, '{8'h00, 8'h80}, 16'h0010, 8'h00);
		send_field(FT_VARUINT, '{8'h80, 8'h01}, 16'h0010, 8'h00);
		send_field(FT_VARINT, '{8'h40}, 16'h0010, 8'h00);
		// Prefixed fields: empty payload, length too big, two payload bytes.
		send_field(FT_LENPFX, '{8'h00}, 16'h0000, 8'h00);
		send_field(FT_LENPFX, '{8'h05}, 16'h0004, 8'h00);
		send_field(FT_LENPFX, '{8'h02, 8'hAA, 8'h55}, 16'h0002, 8'h00);
		// Raw fields: zero length, too big, one byte, two bytes.
		send_field(FT_RAW, '{8'h33}, 16'h0005, 8'h00);
		send_field(FT_RAW, '{8'h33}, 16'h0007, 8'h09);
		send_field(FT_RAW, '{8'hC3}, 16'h0000, 8'h01);
		send_field(FT_RAW, '{8'h01, 8'hFE}, 16'h0001, 8'h02);
	endtask

	task automatic test_random_fields(input int n, input int broken_pct);
		int goal;
		goal = items_sent + n;
		while (items_sent < goal) send_random_field(broken_pct);
	endtask

	// Long and saturated varints, padded prefixes and 64-bit extremes.
	task automatic test_long_varints();
		byte_q_t     seq;
		logic [63:0] len;
		int          pick;
		int          i;
		repeat (30) begin
			seq.delete();
			pick = $urandom_range(0, 3);
			if (pick < 2) begin
				build_varint(seq, $urandom_range(9, 12), $urandom_range(0, 1));
				send_field(pick ? FT_VARINT : FT_VARUINT, seq, 16'($urandom), 8'($urandom));
			end else if (pick == 2) begin
				len = $urandom_range(0, 4);
				build_prefixed(seq, len, 16'(len + 64'd2), $urandom_range(5, 11));
				send_field(FT_LENPFX, seq, 16'(len + 64'd2), 8'($urandom));
			end else begin
				for (i = 0; i < 8; i++)
					seq.push_back((i == 7) ? 8'h80 : rand_data());
				send_field($urandom_range(0, 1) ? FT_I64 : FT_U64, seq, 16'($urandom),
					8'($urandom));
			end
		end
	endtask

	// The sender holds off until every predicted result has come out.
	task automatic test_drain_pause();
		repeat (3) begin
			repeat (20) send_random_field(10);
			push <= 1'b0;
			@(posedge clk);
			while (pending_results.size() != 0) @(posedge clk);
		end
	endtask

	// Back-to-back transfers on both sides.
	task automatic test_steady_stream(input int n);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		test_random_fields(n, 10);
	endtask

	initial begin
		arst_n     = 1'b0;
		push       = 1'b0;
		pop        = 1'b0;
		item       = '0;
		tx_idle    = 1'b1;
		rx_idle    = 1'b1;
		pop_hold   = 0;
		fail_count = 0;
		items_sent = 0;
		cur_type   = '0;
		pay_left   = '0;
		in_pay     = 1'b0;
		clear_scalar();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_fields(700, 15);
		test_long_varints();
		test_drain_pause();
		test_random_fields(200, 40);
		test_steady_stream(400);

		// Let the last results drain out of the pipeline.
		push <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
